@@ src/dcf77_telegram_decoder_unit_macros.svh @@
// assertion shorthands for the decoder top unit
`ifndef DCF77_TELEGRAM_DECODER_UNIT_MACROS_SVH
`define DCF77_TELEGRAM_DECODER_UNIT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define DCF_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define DCF_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/dcf_pkg.sv @@
package dcf_pkg;

    localparam int FRAME_LEN = 59;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_MIN     = 3'd0,
        CFG_PULSE_MAX     = 3'd1,
        CFG_ONE_THRESHOLD = 3'd2,
        CFG_SECOND_LOW    = 3'd3,
        CFG_SECOND_HIGH   = 3'd4,
        CFG_MINUTE_LOW    = 3'd5,
        CFG_MINUTE_HIGH   = 3'd6
    } cfg_index_t;

    localparam logic [CFG_W-1:0] RST_PULSE_MIN     = 16'd50;
    localparam logic [CFG_W-1:0] RST_PULSE_MAX     = 16'd250;
    localparam logic [CFG_W-1:0] RST_ONE_THRESHOLD = 16'd150;
    localparam logic [CFG_W-1:0] RST_SECOND_LOW    = 16'd950;
    localparam logic [CFG_W-1:0] RST_SECOND_HIGH   = 16'd1050;
    localparam logic [CFG_W-1:0] RST_MINUTE_LOW    = 16'd1950;
    localparam logic [CFG_W-1:0] RST_MINUTE_HIGH   = 16'd2050;

    localparam logic [1:0] STATUS_TIME_VALID = 2'd0;
    localparam logic [1:0] STATUS_BAD_COUNT  = 2'd1;
    localparam logic [1:0] STATUS_BAD_FRAME  = 2'd2;

    typedef struct packed {
        logic [15:0] pulse_width;
        logic [15:0] period;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] hours;
        logic [6:0] minutes;
        logic [5:0] day;
        logic [4:0] month;
        logic [7:0] year;
        logic [2:0] weekday;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] pulse_min;
        logic [CFG_W-1:0] pulse_max;
        logic [CFG_W-1:0] one_threshold;
        logic [CFG_W-1:0] second_low;
        logic [CFG_W-1:0] second_high;
        logic [CFG_W-1:0] minute_low;
        logic [CFG_W-1:0] minute_high;
    } cfg_t;

    typedef struct packed {
        logic ends;
        logic len_ok;
    } frame_evt_t;

endpackage

@@ src/dcf_cfg_regs.sv @@
module dcf_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcf_pkg::CFG_W-1:0]       cfg_data,
    output dcf_pkg::cfg_t                   cfg
);
    import dcf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PULSE_MIN:     cfg_next.pulse_min     = cfg_data;
                CFG_PULSE_MAX:     cfg_next.pulse_max     = cfg_data;
                CFG_ONE_THRESHOLD: cfg_next.one_threshold = cfg_data;
                CFG_SECOND_LOW:    cfg_next.second_low    = cfg_data;
                CFG_SECOND_HIGH:   cfg_next.second_high   = cfg_data;
                CFG_MINUTE_LOW:    cfg_next.minute_low    = cfg_data;
                CFG_MINUTE_HIGH:   cfg_next.minute_high   = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_min     <= RST_PULSE_MIN;
            cfg_reg.pulse_max     <= RST_PULSE_MAX;
            cfg_reg.one_threshold <= RST_ONE_THRESHOLD;
            cfg_reg.second_low    <= RST_SECOND_LOW;
            cfg_reg.second_high   <= RST_SECOND_HIGH;
            cfg_reg.minute_low    <= RST_MINUTE_LOW;
            cfg_reg.minute_high   <= RST_MINUTE_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/dcf_frame.sv @@
module dcf_frame #(
    parameter int FRAME_CAPACITY = 65
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  dcf_pkg::item_t                  item,
    input  dcf_pkg::cfg_t                   cfg,
    output dcf_pkg::frame_evt_t             evt,
    output logic [dcf_pkg::FRAME_LEN-1:0]   frame_bits
);
    import dcf_pkg::*;

    localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);

    logic [CNT_W-1:0]     bit_count_reg;
    logic [CNT_W-1:0]     bit_count_next;
    logic [FRAME_LEN-1:0] frame_bits_reg;
    logic [FRAME_LEN-1:0] frame_bits_next;
    logic [CNT_W-1:0]     count_inc;
    logic                 pulse_ok;
    logic                 in_second;
    logic                 in_minute;
    logic                 item_ok;
    logic                 one_bit;

    always_comb
    begin
        pulse_ok  = (cfg.pulse_min <= item.pulse_width) && (item.pulse_width <= cfg.pulse_max);
        in_second = (cfg.second_low <= item.period) && (item.period <= cfg.second_high);
        in_minute = (cfg.minute_low <= item.period) && (item.period <= cfg.minute_high);
        item_ok   = pulse_ok && (in_second || in_minute);
        one_bit   = item.pulse_width > cfg.one_threshold;
        count_inc = bit_count_reg + CNT_W'(1);
    end

    // new bit lands at the current count; positions past the frame length are dropped
    always_comb
    begin
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            if (fire && item_ok && (bit_count_reg == CNT_W'(i)))
                frame_bits_next[i] = one_bit;
            else
                frame_bits_next[i] = frame_bits_reg[i];
        end
    end

    always_comb
    begin
        bit_count_next = bit_count_reg;
        if (fire)
        begin
            if (!item_ok || in_minute)
                bit_count_next = '0;
            else if (count_inc == CNT_W'(FRAME_CAPACITY))
                bit_count_next = '0;
            else
                bit_count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_count_reg <= '0;
        else
            bit_count_reg <= bit_count_next;
    end

    always_ff @(posedge clk)
    begin
        frame_bits_reg <= frame_bits_next;
    end

    assign evt.ends   = fire && item_ok && in_minute;
    assign evt.len_ok = count_inc == CNT_W'(FRAME_LEN);
    assign frame_bits = frame_bits_next;

endmodule

@@ src/dcf_decode.sv @@
module dcf_decode (
    input  logic [dcf_pkg::FRAME_LEN-1:0]   frame_bits,
    input  logic                            len_ok,
    output dcf_pkg::result_t                result
);
    import dcf_pkg::*;

    logic       frame_bad;
    logic [6:0] hours_sum;
    logic [6:0] minutes_sum;
    logic [6:0] day_sum;
    logic [5:0] month_sum;
    logic [8:0] year_sum;
    logic [2:0] wd;

    // x * 10 as (x << 3) + (x << 1)
    always_comb
    begin
        frame_bad = frame_bits[0] || !frame_bits[20] || (^frame_bits[28:21])
                    || (^frame_bits[35:29]) || (^frame_bits[58:36]);
        hours_sum   = {2'b0, frame_bits[34:33], 3'b0} + {4'b0, frame_bits[34:33], 1'b0}
                      + {3'b0, frame_bits[32:29]};
        minutes_sum = {1'b0, frame_bits[27:25], 3'b0} + {3'b0, frame_bits[27:25], 1'b0}
                      + {3'b0, frame_bits[24:21]};
        day_sum     = {2'b0, frame_bits[41:40], 3'b0} + {4'b0, frame_bits[41:40], 1'b0}
                      + {3'b0, frame_bits[39:36]};
        month_sum   = {2'b0, frame_bits[49], 3'b0} + {4'b0, frame_bits[49], 1'b0}
                      + {2'b0, frame_bits[48:45]};
        year_sum    = {2'b0, frame_bits[57:54], 3'b0} + {4'b0, frame_bits[57:54], 1'b0}
                      + {5'b0, frame_bits[53:50]};
        wd          = frame_bits[44:42];

        result = '0;
        if (!len_ok)
        begin
            result.status = STATUS_BAD_COUNT;
        end
        else if (frame_bad)
        begin
            result.status = STATUS_BAD_FRAME;
        end
        else
        begin
            result.status  = STATUS_TIME_VALID;
            result.hours   = hours_sum[5:0];
            result.minutes = minutes_sum[6:0];
            result.day     = day_sum[5:0];
            result.month   = month_sum[4:0];
            result.year    = year_sum[7:0];
            // weekday 7 (sunday) folds to 0
            result.weekday = (wd == 3'd7) ? 3'd0 : wd;
        end
    end

endmodule

@@ src/dcf77_telegram_decoder_unit.sv @@
// channel   dir  handshake                payload
// item      in   item_valid / item_stall  item   (pulse_width, period)
// result    out  result_valid / result_stall  result (status and decoded time)
// cfg       in   cfg_we                   cfg_index, cfg_data
//
// one item per cycle unless the result stalls; a frame-ending item passes the
// input register, then frame update and decode into the result register
// reset clears the frame count and the valid flags and sets the cfg to defaults
// a stalled result holds the pipe; item_stall rises only while the input
// register is full and the result register is blocked
module dcf77_telegram_decoder_unit #(
    parameter int FRAME_CAPACITY = 65
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  dcf_pkg::item_t                  item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output dcf_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [dcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcf_pkg::CFG_W-1:0]       cfg_data
);
    import dcf_pkg::*;

    `include "dcf77_telegram_decoder_unit_macros.svh"

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    item_t                s1_item_reg;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    result_t              result_reg;
    result_t              decoded;
    cfg_t                 cfg;
    frame_evt_t           evt;
    logic [FRAME_LEN-1:0] frame_bits;
    logic                 advance;
    logic                 fire;
    logic                 take;

    dcf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dcf_frame #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (s1_item_reg),
        .cfg        (cfg),
        .evt        (evt),
        .frame_bits (frame_bits)
    );

    dcf_decode u_decode (
        .frame_bits (frame_bits),
        .len_ok     (evt.len_ok),
        .result     (decoded)
    );

    always_comb
    begin
        advance    = !result_valid_reg || !result_stall;
        fire       = s1_valid_reg && advance;
        item_stall = s1_valid_reg && !advance;
        take       = item_valid && !item_stall;

        if (take)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            result_valid_next = evt.ends;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_item_reg <= item;
        if (evt.ends)
            result_reg <= decoded;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `DCF_ASSERT_IMPLY(a_result_from_item, $rose(result_valid_reg), $past(s1_valid_reg), "result without item")
    `DCF_ASSERT_IMPLY(a_stall_only_when_blocked, item_stall, result_valid_reg && result_stall, "input stalled while output free")
    `DCF_ASSERT_IMPLY(a_failed_frame_zero, result_valid_reg && (result_reg.status != STATUS_TIME_VALID), (result_reg.hours == 6'd0) && (result_reg.minutes == 7'd0) && (result_reg.year == 8'd0), "failed frame carries data")
    `DCF_ASSERT_ALWAYS(a_status_known, !result_valid_reg || (result_reg.status != 2'd3), "undefined status code")

endmodule
